// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the load meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CLM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CLM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define CLM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/clm_pkg.sv -----
// Constants, codes and types shared by the CPU load meter quantizer.
`timescale 1ns / 1ps

package clm_pkg;

  localparam int MAX_CPUS   = 256;
  localparam int RESOLUTION = 1000;

  localparam int CPU_W    = 9;
  localparam int TICK_W   = 48;
  localparam int CNT_W    = 52;
  localparam int THR_W    = 10;
  localparam int LOAD_W   = 10;
  localparam int LVL8_W   = 4;
  localparam int LVL4_W   = 3;
  localparam int STATUS_W = 2;

  localparam int CPU_AW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int QUO_W  = $clog2(RESOLUTION + 1);
  localparam int NUM_W  = CNT_W + QUO_W;
  localparam int CMP_W  = (QUO_W > THR_W) ? QUO_W : THR_W;

  localparam int LEVELS_EIGHTHS  = 8;
  localparam int LEVELS_QUARTERS = 4;
  localparam int NUM8_W = THR_W + 3;
  localparam int NUM4_W = THR_W + 2;

  localparam logic [THR_W-1:0] LOW_THR_RESET  = 10'd5;
  localparam logic [THR_W-1:0] HIGH_THR_RESET = 10'd900;

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_LOW_THRESHOLD  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_THRESHOLD = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SKIPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [CPU_W-1:0]    cpu;
    logic [STATUS_W-1:0] status;
  } clm_side_t;

endpackage

// ----- hw/rtl/cpu_load_meter_quantizer.sv -----
// Top level of the CPU load meter quantizer: sums, per-CPU state, ratio and levels.
// Seventeen register stages: S1 to S4, the ten divider stages, then QA, QB and QC.
// Throughput is one item per cycle while out_stall is low, set by the fully pipelined ten-stage divider.
// The previous-count store is a 256-entry memory with one valid flip-flop per entry.
// Synchronous reset clears all valid bits and the thresholds return to 5 and 900.
// No clearing pass is needed, so in_stall is low and items are taken right after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpu_load_meter_quantizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [clm_pkg::CPU_W-1:0]     cpu_index,
  input  logic [clm_pkg::TICK_W-1:0]    ticks_user,
  input  logic [clm_pkg::TICK_W-1:0]    ticks_nice,
  input  logic [clm_pkg::TICK_W-1:0]    ticks_system,
  input  logic [clm_pkg::TICK_W-1:0]    ticks_idle,
  input  logic [clm_pkg::TICK_W-1:0]    ticks_iowait,
  input  logic [clm_pkg::TICK_W-1:0]    ticks_irq,
  input  logic [clm_pkg::TICK_W-1:0]    ticks_softirq,
  input  logic [clm_pkg::TICK_W-1:0]    ticks_steal,
  input  logic [clm_pkg::TICK_W-1:0]    ticks_guest,
  input  logic [clm_pkg::TICK_W-1:0]    ticks_guest_nice,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [clm_pkg::CPU_W-1:0]     cpu_echo,
  output logic [clm_pkg::LOAD_W-1:0]    load_value,
  output logic [clm_pkg::LVL8_W-1:0]    level_eighths,
  output logic [clm_pkg::LVL4_W-1:0]    level_quarters,
  output logic [clm_pkg::STATUS_W-1:0]  status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [clm_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [clm_pkg::THR_W-1:0]     cfg_data
);
  import clm_pkg::*;

  // Configuration registers.
  logic [THR_W-1:0] low_thr;
  logic [THR_W-1:0] high_thr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr  <= LOW_THR_RESET;
      high_thr <= HIGH_THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_THRESHOLD:  low_thr  <= cfg_data;
        REG_HIGH_THRESHOLD: high_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its content moves on.
  logic en_s1, en_s2, en_s3, en_s4, en_qa, en_qb, en_qc;
  logic s1_v, s2_v, s3_v, s4_v, qa_v, qb_v;
  logic div_in_ready, div_out_valid;

  assign en_qc    = !out_valid || !out_stall;
  assign en_qb    = !qb_v || en_qc;
  assign en_qa    = !qa_v || en_qb;
  assign en_s4    = !s4_v || div_in_ready;
  assign en_s3    = !s3_v || en_s4;
  assign en_s2    = !s2_v || en_s3;
  assign en_s1    = !s1_v || en_s2;
  assign in_stall = !en_s1;

  // Stage 1: partial sums of the counters.
  logic [CPU_W-1:0] s1_cpu;
  logic             s1_oor;
  logic [CNT_W-1:0] s1_busy_a, s1_busy_b, s1_excl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en_s1) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      s1_cpu    <= cpu_index;
      s1_oor    <= {1'b0, cpu_index} >= (CPU_W + 1)'(MAX_CPUS);
      s1_busy_a <= CNT_W'(ticks_user) + CNT_W'(ticks_nice) + CNT_W'(ticks_system)
                 + CNT_W'(ticks_irq);
      s1_busy_b <= CNT_W'(ticks_softirq) + CNT_W'(ticks_guest) + CNT_W'(ticks_guest_nice);
      s1_excl   <= CNT_W'(ticks_idle) + CNT_W'(ticks_iowait) + CNT_W'(ticks_steal);
    end
  end

  // Stage 2: busy and total, with the previous counts read from the store.
  logic [2*CNT_W-1:0] state_mem [MAX_CPUS];
  logic [MAX_CPUS-1:0] entry_written;

  logic [CPU_W-1:0]   s2_cpu;
  logic               s2_oor;
  logic [CNT_W-1:0]   s2_busy, s2_total;
  logic [2*CNT_W-1:0] s2_mem_rd;
  logic               s2_rd_written;
  logic               s2_fwd_hit;
  logic [CNT_W-1:0]   s2_fwd_busy, s2_fwd_total;
  logic               s2_skip;
  logic               state_wr;

  assign s2_skip  = s2_oor || (s2_total == '0);
  assign state_wr = s2_v && !s2_skip && en_s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en_s2) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s2) begin
      s2_cpu   <= s1_cpu;
      s2_oor   <= s1_oor;
      s2_busy  <= s1_busy_a + s1_busy_b;
      s2_total <= s1_busy_a + s1_busy_b + s1_excl;
    end
  end

  // The item leaving stage 2 writes at the same edge as this read, so its
  // counts are forwarded when it belongs to the same CPU.
  always_ff @(posedge clk) begin
    if (en_s2 && s1_v) begin
      s2_mem_rd     <= state_mem[s1_cpu[CPU_AW-1:0]];
      s2_rd_written <= entry_written[s1_cpu[CPU_AW-1:0]];
      s2_fwd_hit    <= s2_v && !s2_skip && (s2_cpu == s1_cpu);
      s2_fwd_busy   <= s2_busy;
      s2_fwd_total  <= s2_total;
    end
  end

  always_ff @(posedge clk) begin
    if (state_wr) begin
      state_mem[s2_cpu[CPU_AW-1:0]] <= {s2_busy, s2_total};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_written <= '0;
    end else if (state_wr) begin
      entry_written[s2_cpu[CPU_AW-1:0]] <= 1'b1;
    end
  end

  logic [CNT_W-1:0] prev_busy, prev_total;

  always_comb begin
    if (s2_fwd_hit) begin
      prev_busy  = s2_fwd_busy;
      prev_total = s2_fwd_total;
    end else if (s2_rd_written) begin
      prev_busy  = s2_mem_rd[2*CNT_W-1:CNT_W];
      prev_total = s2_mem_rd[CNT_W-1:0];
    end else begin
      prev_busy  = '0;
      prev_total = '0;
    end
  end

  // Stage 3: deltas, wrapping modulo the counter width.
  logic [CPU_W-1:0] s3_cpu;
  logic             s3_skip;
  logic [CNT_W-1:0] s3_db, s3_dt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en_s3) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s3) begin
      s3_cpu  <= s2_cpu;
      s3_skip <= s2_skip;
      s3_db   <= s2_busy - prev_busy;
      s3_dt   <= s2_total - prev_total;
    end
  end

  // Stage 4: scaled numerator, divisor and status.
  clm_side_t        s4_side;
  logic [NUM_W-1:0] s4_num;
  logic [CNT_W-1:0] s4_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en_s4) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s4) begin
      s4_side.cpu <= s3_cpu;
      if (s3_skip) begin
        s4_side.status <= STATUS_SKIPPED;
      end else if (s3_db > s3_dt) begin
        s4_side.status <= STATUS_OVERFLOW;
      end else begin
        s4_side.status <= STATUS_OK;
      end
      s4_num <= NUM_W'(s3_db) * NUM_W'(RESOLUTION);
      s4_den <= (s3_dt == '0) ? CNT_W'(1) : s3_dt;
    end
  end

  logic [QUO_W-1:0] div_quo;
  clm_side_t        div_side;

  clm_ratio_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s4_v),
    .in_ready  (div_in_ready),
    .in_num    (s4_num),
    .in_den    (s4_den),
    .in_side   (s4_side),
    .out_valid (div_out_valid),
    .out_ready (en_qa),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // Stage QA: threshold compares and level numerators.
  logic [CMP_W-1:0] x_c, low_c, high_c;
  logic             x_ge_res, x_lt_low, x_ge_high, thr_flat;
  logic [THR_W-1:0] x_diff;

  assign x_c       = CMP_W'(div_quo);
  assign low_c     = CMP_W'(low_thr);
  assign high_c    = CMP_W'(high_thr);
  assign x_ge_res  = x_c >= CMP_W'(RESOLUTION);
  assign x_lt_low  = x_c < low_c;
  assign x_ge_high = x_c >= high_c;
  assign thr_flat  = high_thr <= low_thr;
  assign x_diff    = THR_W'(x_c - low_c);

  clm_side_t         qa_side;
  logic [LOAD_W-1:0] qa_x;
  logic              qa_full, qa_zero;
  logic [NUM8_W-1:0] qa_num8;
  logic [NUM4_W-1:0] qa_num4;
  logic [THR_W-1:0]  qa_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      qa_v <= 1'b0;
    end else if (en_qa) begin
      qa_v <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_qa) begin
      qa_side <= div_side;
      qa_x    <= LOAD_W'(div_quo);
      qa_full <= x_ge_res || (!x_lt_low && (x_ge_high || thr_flat));
      qa_zero <= !x_ge_res && x_lt_low;
      qa_num8 <= NUM8_W'(x_diff) * NUM8_W'(LEVELS_EIGHTHS - 1);
      qa_num4 <= NUM4_W'(x_diff) * NUM4_W'(LEVELS_QUARTERS - 1);
      qa_den  <= high_thr - low_thr;
    end
  end

  // Stage QB: upper quotient bits of the level divisions.
  logic [NUM8_W-1:0] den8_2, den8_1, r8_a, r8_b;
  logic [NUM4_W-1:0] den4_1, r4_a;
  logic              t8_2, t8_1, t4_1;

  assign den8_2 = NUM8_W'(qa_den) << 2;
  assign t8_2   = qa_num8 >= den8_2;
  assign r8_a   = t8_2 ? qa_num8 - den8_2 : qa_num8;
  assign den8_1 = NUM8_W'(qa_den) << 1;
  assign t8_1   = r8_a >= den8_1;
  assign r8_b   = t8_1 ? r8_a - den8_1 : r8_a;
  assign den4_1 = NUM4_W'(qa_den) << 1;
  assign t4_1   = qa_num4 >= den4_1;
  assign r4_a   = t4_1 ? qa_num4 - den4_1 : qa_num4;

  clm_side_t         qb_side;
  logic [LOAD_W-1:0] qb_x;
  logic              qb_full, qb_zero;
  logic [NUM8_W-1:0] qb_r8;
  logic [NUM4_W-1:0] qb_r4;
  logic [1:0]        qb_q8;
  logic              qb_q4;
  logic [THR_W-1:0]  qb_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      qb_v <= 1'b0;
    end else if (en_qb) begin
      qb_v <= qa_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_qb) begin
      qb_side <= qa_side;
      qb_x    <= qa_x;
      qb_full <= qa_full;
      qb_zero <= qa_zero;
      qb_r8   <= r8_b;
      qb_r4   <= r4_a;
      qb_q8   <= {t8_2, t8_1};
      qb_q4   <= t4_1;
      qb_den  <= qa_den;
    end
  end

  // Stage QC: last quotient bits and the output register.
  logic              t8_0, t4_0;
  logic [LVL8_W-1:0] lvl8;
  logic [LVL4_W-1:0] lvl4;

  assign t8_0 = qb_r8 >= NUM8_W'(qb_den);
  assign t4_0 = qb_r4 >= NUM4_W'(qb_den);

  always_comb begin
    if (qb_full) begin
      lvl8 = LVL8_W'(LEVELS_EIGHTHS);
      lvl4 = LVL4_W'(LEVELS_QUARTERS);
    end else if (qb_zero) begin
      lvl8 = '0;
      lvl4 = '0;
    end else begin
      lvl8 = LVL8_W'({qb_q8, t8_0}) + LVL8_W'(1);
      lvl4 = LVL4_W'({qb_q4, t4_0}) + LVL4_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_qc) begin
      out_valid <= qb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_qc) begin
      cpu_echo <= qb_side.cpu;
      status   <= qb_side.status;
      if (qb_side.status == STATUS_OK) begin
        load_value     <= qb_x;
        level_eighths  <= lvl8;
        level_quarters <= lvl4;
      end else begin
        load_value     <= '0;
        level_eighths  <= '0;
        level_quarters <= '0;
      end
    end
  end

  `CLM_ASSERT_IMPL(a_fault_zero, clk, rst, out_valid && status != STATUS_OK, load_value == '0 && level_eighths == '0 && level_quarters == '0, "faulted result carries a load")
  `CLM_ASSERT_IMPL(a_ok_range, clk, rst, out_valid && status == STATUS_OK, load_value <= LOAD_W'(RESOLUTION) && level_eighths <= LVL8_W'(LEVELS_EIGHTHS) && level_quarters <= LVL4_W'(LEVELS_QUARTERS), "result out of range")
  `CLM_ASSERT_NEXT(a_state_fwd, clk, rst, state_wr && en_s2 && s1_v && s1_cpu == s2_cpu, s2_fwd_hit, "same-CPU update not forwarded")

endmodule

// ----- hw/rtl/clm_ratio_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clm_ratio_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [clm_pkg::NUM_W-1:0] in_num,
  input  logic [clm_pkg::CNT_W-1:0] in_den,
  input  clm_pkg::clm_side_t        in_side,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [clm_pkg::QUO_W-1:0] out_quo,
  output clm_pkg::clm_side_t        out_side
);
  import clm_pkg::*;

  logic             v    [QUO_W];
  logic [NUM_W-1:0] rem  [QUO_W];
  logic [CNT_W-1:0] den  [QUO_W];
  logic [QUO_W-1:0] quo  [QUO_W];
  clm_side_t        side [QUO_W];
  logic [QUO_W:0]   en;

  assign en[QUO_W] = out_ready;

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic             v_src;
    logic [NUM_W-1:0] rem_src;
    logic [CNT_W-1:0] den_src;
    logic [QUO_W-1:0] quo_src;
    clm_side_t        side_src;
    logic [NUM_W-1:0] den_sh;
    logic             take;

    if (j == 0) begin : g_first
      assign v_src    = in_valid;
      assign rem_src  = in_num;
      assign den_src  = in_den;
      assign quo_src  = '0;
      assign side_src = in_side;
    end else begin : g_next
      assign v_src    = v[j-1];
      assign rem_src  = rem[j-1];
      assign den_src  = den[j-1];
      assign quo_src  = quo[j-1];
      assign side_src = side[j-1];
    end

    // Stage j settles quotient bit QUO_W-1-j.
    assign den_sh = NUM_W'(den_src) << (QUO_W - 1 - j);
    assign take   = rem_src >= den_sh;
    assign en[j]  = !v[j] || en[j+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en[j]) begin
        v[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j]  <= take ? rem_src - den_sh : rem_src;
        den[j]  <= den_src;
        quo[j]  <= {quo_src[QUO_W-2:0], take};
        side[j] <= side_src;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[QUO_W-1];
  assign out_quo   = quo[QUO_W-1];
  assign out_side  = side[QUO_W-1];

  `CLM_ASSERT_IMPL(a_den_nonzero, clk, rst, v[0], den[0] != '0, "divider holds a zero divisor")
  `CLM_ASSERT_IMPL(a_rem_bound, clk, rst, v[QUO_W-1] && side[QUO_W-1].status == STATUS_OK, rem[QUO_W-1] < NUM_W'(den[QUO_W-1]), "final remainder not below divisor")
  `CLM_ASSERT_NEXT(a_first_hold, clk, rst, v[0] && !en[0], v[0] && $stable(rem[0]), "held first stage changed")

endmodule
